// ----- design/cbm_pkg.sv -----
// Shared types, codes and helpers of the control bitfield mapper.
`timescale 1ns / 1ps

package cbm_pkg;

    // Default number of shadow register bytes.
    localparam int SHADOW_DEPTH_DEF = 512;

    // Stream widths; the tdata widths are padded to whole bytes.
    localparam int IN_TDATA_W  = 104;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 72;

    // Segment functions.
    localparam logic [1:0] FUNC_WRITE    = 2'd0;
    localparam logic [1:0] FUNC_READ     = 2'd1;
    localparam logic [1:0] FUNC_RAW_LOAD = 2'd2;
    localparam logic [1:0] FUNC_RAW_READ = 2'd3;

    // Write source selection; FILL_CLEAR clears like FILL_ZERO.
    localparam logic [1:0] FILL_VALUE = 2'd0;
    localparam logic [1:0] FILL_ZERO  = 2'd1;
    localparam logic [1:0] FILL_ONES  = 2'd2;
    localparam logic [1:0] FILL_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  reg_address;
        logic [3:0]  field_len;
        logic [2:0]  field_lsb;
        logic [5:0]  value_offset;
        logic        active_low;
        logic [63:0] control_value;
        logic [6:0]  value_bits;
        logic        mirrored;
        logic [1:0]  fill_mode;
        logic        last_segment;
        logic        constant_input;
    } cbm_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic apply;
    } cbm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } cbm_status_t;

    // Full 64-bit bit reversal; pure wiring.
    function automatic logic [63:0] rev64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++)
        begin
            r[63 - i] = v[i];
        end
        return r;
    endfunction

endpackage

// ----- design/cbm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cbm_ctrl.sv -----
// Controller state machine of the control bitfield mapper.
`timescale 1ns / 1ps

module cbm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cbm_pkg::cbm_status_t st,
    output cbm_pkg::cbm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        cmd.clear   = (state_reg == ST_CLEAR);
        cmd.capture = ready_reg & s_tvalid;
        cmd.lookup  = (state_reg == ST_LOOKUP);
        cmd.apply   = (state_reg == ST_APPLY) & st.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (st.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

    // A taken beat always moves on to the lookup cycle.
    a_capture_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_LOOKUP)
        else $error("accepted beat did not enter lookup");

endmodule

// ----- design/cbm_datapath.sv -----
// Datapath: shadow RAM, field extraction and merge, read accumulator, output register.
`timescale 1ns / 1ps

module cbm_datapath #(
    parameter int SHADOW_DEPTH = cbm_pkg::SHADOW_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cbm_pkg::cbm_cmd_t                    cmd,
    output cbm_pkg::cbm_status_t                 st,
    input  cbm_pkg::cbm_item_t                   in_item,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [cbm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tuser
);

    localparam int AW = $clog2(SHADOW_DEPTH);
    localparam int XW = (AW > 9) ? AW : 9;

    cbm_pkg::cbm_item_t item_reg;
    logic [7:0]         fbits_reg;
    logic [7:0]         fmask_reg;
    logic [63:0]        acc_reg;
    logic [63:0]        acc_next;
    logic [AW-1:0]      clr_cnt_reg;
    logic               out_valid_reg;
    logic [63:0]        out_result_reg;
    logic               out_done_reg;
    logic [7:0]         out_byte_reg;

    logic [XW-1:0]      in_addr_x;
    logic [XW-1:0]      item_addr_x;
    logic [AW-1:0]      ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_we;
    logic [7:0]         ram_rdata;

    logic [3:0]         len_c;
    logic [6:0]         vb_c;
    logic [7:0]         lenmask8;
    logic [7:0]         fmask;
    logic [7:0]         fbits;

    logic               in_range;
    logic [7:0]         old_byte;
    logic [7:0]         new_byte;
    logic               wr_en;
    logic [63:0]        result;
    logic               done;

    assign in_addr_x   = XW'(in_item.reg_address);
    assign item_addr_x = XW'(item_reg.reg_address);

    assign ram_we    = cmd.clear | (cmd.apply & wr_en);
    assign ram_waddr = cmd.clear ? clr_cnt_reg : item_addr_x[AW-1:0];
    assign ram_wdata = cmd.clear ? 8'd0 : new_byte;

    cbm_ram #(
        .WIDTH(8),
        .DEPTH(SHADOW_DEPTH)
    ) u_shadow (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.capture),
        .raddr(in_addr_x[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Lookup cycle: build the field mask and the bits a write would place.
    always_comb
    begin
        logic [63:0] ones64;
        logic [63:0] base;
        logic [7:0]  sh;
        logic [7:0]  sel;
        len_c    = (item_reg.field_len > 4'd8) ? 4'd8 : item_reg.field_len;
        vb_c     = (item_reg.value_bits > 7'd64) ? 7'd64 : item_reg.value_bits;
        lenmask8 = 8'((9'd1 << len_c) - 9'd1);
        fmask    = 8'(16'(lenmask8) << item_reg.field_lsb);
        ones64   = (vb_c == 7'd64) ? '1 : ((64'd1 << vb_c) - 64'd1);
        sh       = 8'(item_reg.value_offset);
        case (item_reg.fill_mode)
            cbm_pkg::FILL_VALUE:
            begin
                if (item_reg.mirrored)
                begin
                    // Mirror and offset shift fold into one right shift.
                    base = cbm_pkg::rev64(item_reg.control_value);
                    sh   = 8'd64 - 8'(vb_c) + 8'(item_reg.value_offset);
                end
                else
                begin
                    base = item_reg.control_value;
                end
            end
            cbm_pkg::FILL_ONES:
            begin
                base = ones64;
            end
            default:
            begin
                base = 64'd0;
            end
        endcase
        sel = 8'(base >> sh);
        if (item_reg.active_low)
        begin
            sel = ~sel;
        end
        sel   = sel & lenmask8;
        fbits = 8'(16'(sel) << item_reg.field_lsb);
    end

    // Apply cycle: merge into the shadow byte or assemble the read value.
    always_comb
    begin
        logic [7:0]  rd_bits;
        logic [63:0] acc_new;
        logic [63:0] acc_mir;
        in_range = (32'(item_reg.reg_address) < SHADOW_DEPTH);
        old_byte = in_range ? ram_rdata : 8'd0;
        rd_bits  = ((item_reg.active_low ? ~old_byte : old_byte) & fmask_reg)
                   >> item_reg.field_lsb;
        acc_new  = acc_reg | (64'(rd_bits) << item_reg.value_offset);
        acc_mir  = cbm_pkg::rev64(acc_new) >> (7'd64 - vb_c);
        new_byte = old_byte;
        wr_en    = 1'b0;
        result   = 64'd0;
        done     = 1'b0;
        acc_next = acc_reg;
        case (item_reg.func)
            cbm_pkg::FUNC_WRITE:
            begin
                new_byte = (old_byte & ~fmask_reg) | fbits_reg;
                wr_en    = in_range;
            end
            cbm_pkg::FUNC_RAW_LOAD:
            begin
                new_byte = item_reg.control_value[7:0];
                wr_en    = in_range;
            end
            cbm_pkg::FUNC_READ:
            begin
                if (item_reg.constant_input)
                begin
                    result   = item_reg.control_value;
                    done     = 1'b1;
                    acc_next = 64'd0;
                end
                else if (item_reg.last_segment)
                begin
                    result   = item_reg.mirrored ? acc_mir : acc_new;
                    done     = 1'b1;
                    acc_next = 64'd0;
                end
                else
                begin
                    acc_next = acc_new;
                end
            end
            default:
            begin
                new_byte = old_byte;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        if (cmd.lookup)
        begin
            fbits_reg <= fbits;
            fmask_reg <= fmask;
        end
        if (cmd.apply)
        begin
            out_result_reg <= result;
            out_done_reg   <= done;
            out_byte_reg   <= in_range ? new_byte : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                acc_reg <= acc_next;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.clear_last = (clr_cnt_reg == AW'(SHADOW_DEPTH - 1));
    assign st.out_free   = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_byte_reg, out_result_reg};
    assign m_tuser  = out_done_reg;

    a_apply_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an untaken beat");

    a_clear_excludes_apply: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear && (cmd.apply || cmd.capture)))
        else $error("item handled during the clearing pass");

    a_result_zero_unless_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |-> out_result_reg == 64'd0)
        else $error("nonzero result without a completed value");

    a_acc_cleared_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && item_reg.func == cbm_pkg::FUNC_READ
         && (item_reg.last_segment || item_reg.constant_input)) |=> acc_reg == 64'd0)
        else $error("accumulator not cleared after a completed read");

endmodule

// ----- design/control_bitfield_mapper_unit.sv -----
// Top level of the control bitfield mapper: stream ports, controller and datapath.
`timescale 1ns / 1ps

// The block keeps a byte-wide shadow of panel I/O registers and maps control
// values onto bit fields of those bytes, one wiring segment per input beat.
// Input beats arrive on the s_ group; s_tuser carries the segment function
// (write, read, raw load, raw read) and s_tlast marks the final segment of a
// control. Every input beat yields exactly one output beat on the m_ group,
// carrying the assembled control value, the shadow byte after the step, and
// in m_tuser a flag that is set when the value is a completed read.
// A beat passes through these steps: acceptance issues the shadow RAM read,
// the lookup step builds the field mask and write bits, and the apply step
// does the read-modify-write and loads the output register. The block takes
// no new beat until the apply step of the last one is done, as the registered
// RAM read lies in series with the merge and write back. After reset the
// shadow RAM is swept to zero, one byte a cycle; s_tready stays low meanwhile.
// When the receiver stalls, the output beat holds; one more input beat is
// taken and looked up, and it waits in the merge step until the output
// register frees.
module control_bitfield_mapper_unit #(
    parameter int SHADOW_DEPTH = cbm_pkg::SHADOW_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: reg_address, field_len, field_lsb, value_offset, active_low,
    // control_value, value_bits, mirrored, fill_mode, constant_input, zero pad.
    input  logic [cbm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // func.
    input  logic [cbm_pkg::IN_TUSER_W-1:0]    s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: result_value, reg_byte.
    output logic [cbm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // value_done.
    output logic                              m_tuser
);

    cbm_pkg::cbm_item_t   in_item;
    cbm_pkg::cbm_cmd_t    cmd;
    cbm_pkg::cbm_status_t st;

    // Unpack the input beat into its segment fields.
    always_comb
    begin
        in_item.func           = s_tuser;
        in_item.reg_address    = s_tdata[8:0];
        in_item.field_len      = s_tdata[12:9];
        in_item.field_lsb      = s_tdata[15:13];
        in_item.value_offset   = s_tdata[21:16];
        in_item.active_low     = s_tdata[22];
        in_item.control_value  = s_tdata[86:23];
        in_item.value_bits     = s_tdata[93:87];
        in_item.mirrored       = s_tdata[94];
        in_item.fill_mode      = s_tdata[96:95];
        in_item.constant_input = s_tdata[97];
        in_item.last_segment   = s_tlast;
    end

    cbm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    cbm_datapath #(
        .SHADOW_DEPTH(SHADOW_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .in_item (in_item),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ----- test/cbm_checker.sv -----
// Scoreboard for the control bitfield mapper: predicts each result beat and compares it.
`timescale 1ns / 1ps

module cbm_checker
    import cbm_pkg::*;
#(
    parameter int SHADOW_DEPTH = SHADOW_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic [IN_TUSER_W-1:0]   s_tuser,
    input  logic                    s_tlast,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    m_tuser,
    output int                      fail_count,
    output int                      pending,
    output int                      checked_count,
    output int                      reads_done
);

    typedef struct {
        logic [63:0] value;
        logic        done;
        logic [7:0]  reg_byte;
    } cbm_result_t;

    logic [7:0]  shadow_copy [0:SHADOW_DEPTH-1];
    logic [63:0] read_acc;
    cbm_result_t result_q [$];
    cbm_result_t want;
    cbm_result_t got;
    cbm_item_t   beat;
    int          shown;

    function automatic logic [63:0] reverse_bits(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            if (v[i])
                r[n - 1 - i] = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [7:0] shadow_peek(input logic [8:0] addr);
        if (addr < SHADOW_DEPTH)
            return shadow_copy[addr];
        return 8'h00;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        fail_count++;
        if (shown < 30)
        begin
            shown++;
            $display("%0t checker: %s got %h want %h", $time, what, seen, wanted);
        end
    endtask

    task automatic map_segment(input cbm_item_t it, output cbm_result_t res);
        int          len;
        int          vbits;
        int          fmask;
        int          bits;
        logic [63:0] src;
        logic [63:0] v;
        len   = (it.field_len > 8) ? 8 : int'(it.field_len);
        vbits = (it.value_bits > 64) ? 64 : int'(it.value_bits);
        fmask = (((1 << len) - 1) << it.field_lsb) & 255;
        res.value = '0;
        res.done  = 1'b0;
        case (it.func)
            FUNC_WRITE:
            begin
                if (it.fill_mode == FILL_ZERO || it.fill_mode == FILL_CLEAR)
                    src = '0;
                else if (it.fill_mode == FILL_ONES)
                    src = (vbits >= 64) ? '1 : ((64'd1 << vbits) - 64'd1);
                else if (it.mirrored)
                    src = reverse_bits(it.control_value, vbits);
                else
                    src = it.control_value;
                bits = int'((src >> it.value_offset) & 64'hFF);
                if (it.active_low)
                    bits = ~bits & 255;
                bits = bits & ((1 << len) - 1);
                bits = (bits << it.field_lsb) & 255;
                if (it.reg_address < SHADOW_DEPTH)
                    shadow_copy[it.reg_address] =
                        8'((int'(shadow_copy[it.reg_address]) & ~fmask & 255) | bits);
            end
            FUNC_READ:
            begin
                if (it.constant_input)
                begin
                    res.value = it.control_value;
                    res.done  = 1'b1;
                    read_acc  = '0;
                end
                else
                begin
                    bits = int'(shadow_peek(it.reg_address));
                    if (it.active_low)
                        bits = ~bits & 255;
                    bits = (bits & fmask) >> it.field_lsb;
                    read_acc = read_acc | (64'(bits) << it.value_offset);
                    if (it.last_segment)
                    begin
                        v = read_acc;
                        if (it.mirrored)
                            v = reverse_bits(v, vbits);
                        res.value = v;
                        res.done  = 1'b1;
                        read_acc  = '0;
                    end
                end
            end
            FUNC_RAW_LOAD:
            begin
                if (it.reg_address < SHADOW_DEPTH)
                    shadow_copy[it.reg_address] = it.control_value[7:0];
            end
            default:
            begin
            end
        endcase
        res.reg_byte = shadow_peek(it.reg_address);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SHADOW_DEPTH; i++)
                shadow_copy[i] = 8'h00;
            read_acc      = '0;
            result_q.delete();
            fail_count    = 0;
            pending       = 0;
            checked_count = 0;
            reads_done    = 0;
            shown         = 0;
        end
        else
        begin
            // Results first: a beat accepted at this edge cannot show up at the same edge.
            if (m_tvalid && m_tready)
            begin
                got.value    = m_tdata[63:0];
                got.reg_byte = m_tdata[71:64];
                got.done     = m_tuser;
                if (result_q.size() == 0)
                begin
                    report_mismatch("result beat with nothing outstanding", got.value, '0);
                end
                else
                begin
                    want = result_q.pop_front();
                    checked_count++;
                    if (got.done)
                        reads_done++;
                    if (got.value !== want.value)
                        report_mismatch("result_value", got.value, want.value);
                    if (got.done !== want.done)
                        report_mismatch("value_done", 64'(got.done), 64'(want.done));
                    if (got.reg_byte !== want.reg_byte)
                        report_mismatch("reg_byte", 64'(got.reg_byte), 64'(want.reg_byte));
                end
            end
            if (s_tvalid && s_tready)
            begin
                beat.func           = s_tuser;
                beat.last_segment   = s_tlast;
                beat.reg_address    = s_tdata[8:0];
                beat.field_len      = s_tdata[12:9];
                beat.field_lsb      = s_tdata[15:13];
                beat.value_offset   = s_tdata[21:16];
                beat.active_low     = s_tdata[22];
                beat.control_value  = s_tdata[86:23];
                beat.value_bits     = s_tdata[93:87];
                beat.mirrored       = s_tdata[94];
                beat.fill_mode      = s_tdata[96:95];
                beat.constant_input = s_tdata[97];
                map_segment(beat, want);
                result_q.push_back(want);
            end
            pending = result_q.size();
        end
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for the control bitfield mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

// The top drives segment beats into the mapper and leaves all prediction and
// comparison to cbm_checker. Stimulus is a directed opener covering raw byte
// access, the field and value length extremes, every fill mode, mirroring,
// active-low fields and constant inputs, followed by random controls: each
// control is written over one to four segments and usually read back through
// the same wiring, so reads see real data. About one control in seven is
// replaced by a noise beat with every field random over its full width.
module tb;
    import cbm_pkg::*;

    // Cycles with no beat accepted on either side before the run is abandoned.
    // It must cover the shadow clearing sweep after reset and the long stall.
    localparam int STALL_LIMIT = 4000;
    localparam int BEAT_TARGET = 600;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [IN_TUSER_W-1:0]   s_tuser;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    m_tuser;

    int fail_count;
    int pending;
    int checked_count;
    int reads_done;
    int sent_count;
    int idle_cycles;

    control_bitfield_mapper_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cbm_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count),
        .reads_done    (reads_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Neither side idles during this window of the run.
    function automatic bit calm_window();
        return sent_count >= 300 && sent_count < 420;
    endfunction

    // Most addresses come from a small pool so that reads find written data.
    function automatic logic [8:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 9'd511;
        if (r < 75)
            return 9'($urandom_range(0, 15));
        return 9'($urandom_range(0, 511));
    endfunction

    function automatic logic [3:0] pick_length();
        if ($urandom_range(0, 99) < 10)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    // Offers one beat and returns at the falling edge after it was taken.
    // Outside the calm window, random gaps drop tvalid before the beat goes out.
    task automatic send_beat(input cbm_item_t it);
        if (!calm_window() && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        // Lowest bits first: reg_address, field_len, field_lsb, value_offset,
        // active_low, control_value, value_bits, mirrored, fill_mode, constant_input.
        s_tdata  <= {6'd0, it.constant_input, it.fill_mode, it.mirrored, it.value_bits,
                     it.control_value, it.active_low, it.value_offset, it.field_lsb,
                     it.field_len, it.reg_address};
        s_tuser  <= it.func;
        s_tlast  <= it.last_segment;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic put(input logic [1:0] func, input logic [8:0] addr,
                       input logic [3:0] len, input logic [2:0] lsb,
                       input logic [5:0] offset, input logic act_low,
                       input logic [63:0] cval, input logic [6:0] vbits,
                       input logic mirror, input logic [1:0] fill,
                       input logic last, input logic cst);
        cbm_item_t it;
        it.func           = func;
        it.reg_address    = addr;
        it.field_len      = len;
        it.field_lsb      = lsb;
        it.value_offset   = offset;
        it.active_low     = act_low;
        it.control_value  = cval;
        it.value_bits     = vbits;
        it.mirrored       = mirror;
        it.fill_mode      = fill;
        it.last_segment   = last;
        it.constant_input = cst;
        send_beat(it);
    endtask

    // Stops offering and waits until every outstanding result has come back,
    // then lets the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic noise_beat();
        put(2'($urandom_range(0, 3)), pick_address(), 4'($urandom_range(0, 15)),
            3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), 1'($urandom),
            {$urandom, $urandom}, 7'($urandom_range(0, 127)), 1'($urandom),
            2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
    endtask

    // One control spread over one to four segments: written, then usually read back
    // through the same wiring with the last segment flagged.
    task automatic random_control();
        cbm_item_t   segs [4];
        int          nseg;
        int          r;
        logic [6:0]  vbits;
        logic [63:0] cval;
        logic        mirror;
        nseg = $urandom_range(1, 4);
        r    = $urandom_range(0, 99);
        if (r < 5)
            vbits = 7'd0;
        else if (r < 10)
            vbits = 7'($urandom_range(65, 127));
        else if (r < 25)
            vbits = 7'd64;
        else
            vbits = 7'($urandom_range(1, 64));
        cval   = {$urandom, $urandom};
        mirror = 1'($urandom);
        for (int k = 0; k < nseg; k++)
        begin
            segs[k].reg_address    = pick_address();
            segs[k].field_len      = pick_length();
            segs[k].field_lsb      = 3'($urandom_range(0, 7));
            segs[k].value_offset   = ($urandom_range(0, 1) != 0) ? 6'(k * 8)
                                                                 : 6'($urandom_range(0, 63));
            segs[k].active_low     = 1'($urandom);
            segs[k].control_value  = cval;
            segs[k].value_bits     = vbits;
            segs[k].mirrored       = mirror;
            segs[k].fill_mode      = ($urandom_range(0, 99) < 85) ? FILL_VALUE
                                                                  : 2'($urandom_range(1, 3));
            segs[k].last_segment   = (k == nseg - 1);
            segs[k].constant_input = 1'b0;
            segs[k].func           = FUNC_WRITE;
            send_beat(segs[k]);
        end
        if ($urandom_range(0, 99) < 80)
        begin
            for (int k = 0; k < nseg; k++)
            begin
                segs[k].func = FUNC_READ;
                // Now and then the control turns out to be unwired.
                segs[k].constant_input = ($urandom_range(0, 99) < 3);
                send_beat(segs[k]);
            end
        end
    endtask

    task automatic directed_opener();
        logic [63:0] pattern;
        pattern = {$urandom, $urandom};
        // Raw access at both ends of the shadow, plus a byte never written.
        put(FUNC_RAW_LOAD, 9'd0,   4'd0, 3'd0, 6'd0, 1'b0, 64'hFF, 7'd64, 1'b0, FILL_VALUE,
            1'b0, 1'b0);
        put(FUNC_RAW_LOAD, 9'd511, 4'd0, 3'd0, 6'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFA5, 7'd64,
            1'b0, FILL_VALUE, 1'b0, 1'b0);
        put(FUNC_RAW_READ, 9'd0,   4'd0, 3'd0, 6'd0, 1'b0, '0, 7'd64, 1'b0, FILL_VALUE,
            1'b0, 1'b0);
        put(FUNC_RAW_READ, 9'd511, 4'd0, 3'd0, 6'd0, 1'b0, '1, 7'd64, 1'b1, FILL_CLEAR,
            1'b1, 1'b1);
        put(FUNC_RAW_READ, 9'd300, 4'd0, 3'd0, 6'd0, 1'b0, '0, 7'd64, 1'b0, FILL_VALUE,
            1'b0, 1'b0);
        // Full byte field, empty field, and a length above eight with active-low.
        put(FUNC_WRITE, 9'd5, 4'd8, 3'd0, 6'd0, 1'b0, '1, 7'd64, 1'b0, FILL_VALUE, 1'b0, 1'b0);
        put(FUNC_WRITE, 9'd5, 4'd0, 3'd3, 6'd0, 1'b0, '0, 7'd64, 1'b0, FILL_VALUE, 1'b0, 1'b0);
        put(FUNC_WRITE, 9'd5, 4'd15, 3'd4, 6'd60, 1'b1, '0, 7'd64, 1'b0, FILL_VALUE,
            1'b0, 1'b0);
        // Fill modes, including the all-ones source with no value bits and the
        // fourth code that clears.
        put(FUNC_WRITE, 9'd5, 4'd4, 3'd2, 6'd0, 1'b0, '1, 7'd64, 1'b0, FILL_ZERO, 1'b0, 1'b0);
        put(FUNC_WRITE, 9'd6, 4'd8, 3'd0, 6'd0, 1'b0, '1, 7'd0, 1'b0, FILL_ONES, 1'b0, 1'b0);
        put(FUNC_WRITE, 9'd6, 4'd8, 3'd0, 6'd0, 1'b0, '1, 7'd64, 1'b0, FILL_CLEAR, 1'b0, 1'b0);
        put(FUNC_WRITE, 9'd7, 4'd8, 3'd0, 6'd56, 1'b0, '0, 7'd127, 1'b0, FILL_ONES,
            1'b0, 1'b0);
        // Mirroring with no value bits, the full 64 bits and an oversize length.
        put(FUNC_WRITE, 9'd8, 4'd8, 3'd0, 6'd0, 1'b0, pattern, 7'd0, 1'b1, FILL_VALUE,
            1'b0, 1'b0);
        put(FUNC_WRITE, 9'd8, 4'd1, 3'd7, 6'd63, 1'b0, 64'd1, 7'd64, 1'b1, FILL_VALUE,
            1'b0, 1'b0);
        put(FUNC_WRITE, 9'd9, 4'd8, 3'd0, 6'd8, 1'b0, pattern, 7'd100, 1'b1, FILL_VALUE,
            1'b0, 1'b0);
        // Reads: a partial segment, then a completing active-low mirrored one.
        put(FUNC_READ, 9'd5, 4'd4, 3'd0, 6'd0, 1'b0, '0, 7'd64, 1'b0, FILL_VALUE, 1'b0, 1'b0);
        put(FUNC_READ, 9'd7, 4'd8, 3'd0, 6'd60, 1'b1, '0, 7'd64, 1'b1, FILL_VALUE,
            1'b1, 1'b0);
        // A constant input completes even without the last-segment flag and
        // throws away what was gathered so far.
        put(FUNC_READ, 9'd8, 4'd8, 3'd0, 6'd0, 1'b0, pattern, 7'd64, 1'b0, FILL_VALUE,
            1'b0, 1'b0);
        put(FUNC_READ, 9'd9, 4'd8, 3'd0, 6'd0, 1'b0, pattern, 7'd64, 1'b0, FILL_VALUE,
            1'b0, 1'b1);
        put(FUNC_READ, 9'd8, 4'd8, 3'd7, 6'd63, 1'b0, '0, 7'd0, 1'b1, FILL_VALUE, 1'b1, 1'b0);
        put(FUNC_READ, 9'd9, 4'd12, 3'd0, 6'd8, 1'b0, '0, 7'd127, 1'b1, FILL_VALUE,
            1'b1, 1'b0);
        put(FUNC_READ, 9'd511, 4'd8, 3'd0, 6'd0, 1'b1, '1, 7'd64, 1'b0, FILL_VALUE,
            1'b1, 1'b1);
    endtask

    // Result side: random back-pressure, one long hold-off once the run is
    // under way so the block fills up and drops s_tready, and a calm window.
    initial
    begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!held && sent_count >= 150)
            begin
                held      = 1'b1;
                hold_left = 300;
                m_tready <= 1'b0;
            end
            else if (calm_window())
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= 8);
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a beat for too long.
    initial
    begin : watchdog
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t watchdog: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("tb: errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        bit paused;
        paused     = 1'b0;
        sent_count = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_opener();
        drain();

        while (sent_count < BEAT_TARGET)
        begin
            // Once mid-run the sender stops until every result is back.
            if (!paused && sent_count >= 480)
            begin
                paused = 1'b1;
                drain();
            end
            if ($urandom_range(0, 99) < 15)
                noise_beat();
            else
                random_control();
        end

        drain();
        $display("summary: %0d segment beats sent, %0d results checked, %0d completed reads",
                 sent_count, checked_count, reads_done);
        $display("summary: raw byte access, all fill modes, mirroring, active-low fields, %s",
                 "constant inputs, a long output stall and a full drain");
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
